// File: hdl/chol_pkg.sv
`default_nettype none
package chol_pkg;

    localparam int MAX_DIM = 8;
    localparam int DIM_W   = 3;
    localparam int ADDR_W  = 2 * DIM_W;
    localparam int DEPTH   = MAX_DIM * MAX_DIM;
    localparam int DATA_W  = 32;
    localparam int ACC_W   = 64;

    localparam logic CFG_SIZE = 1'b0;
    localparam logic CFG_TOL  = 1'b1;

    typedef enum logic [3:0] {
        S_LOAD,
        S_ELEM,
        S_MRD,
        S_MMUL,
        S_MACC,
        S_REM,
        S_DEC,
        S_WAIT,
        S_FAIL,
        S_ORD,
        S_OVAL
    } state_t;

    function automatic logic signed [ACC_W-1:0] sat_add64(
        input logic signed [ACC_W-1:0] a,
        input logic signed [ACC_W-1:0] b
    );
        logic signed [ACC_W:0] s;
        begin
            s = {a[ACC_W-1], a} + {b[ACC_W-1], b};
            if (s[ACC_W] != s[ACC_W-1])
                sat_add64 = s[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
            else
                sat_add64 = s[ACC_W-1:0];
        end
    endfunction

    function automatic logic signed [ACC_W-1:0] sat_sub64(
        input logic signed [ACC_W-1:0] a,
        input logic signed [ACC_W-1:0] b
    );
        logic signed [ACC_W:0] s;
        begin
            s = {a[ACC_W-1], a} - {b[ACC_W-1], b};
            if (s[ACC_W] != s[ACC_W-1])
                sat_sub64 = s[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
            else
                sat_sub64 = s[ACC_W-1:0];
        end
    endfunction

endpackage
`default_nettype wire

// File: hdl/chol_sqrt.sv
`default_nettype none
module chol_sqrt (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              start,
    input  wire logic [chol_pkg::ACC_W-1:0]        radicand,
    output logic                                   done,
    output logic signed [chol_pkg::DATA_W-1:0]     root
);

    logic [chol_pkg::ACC_W-1:0] x_reg;
    logic [chol_pkg::ACC_W-1:0] r_reg;
    logic [chol_pkg::ACC_W-1:0] b_reg;
    logic [4:0]                 cnt_reg;
    logic                       busy_reg;
    logic                       done_reg;
    logic [chol_pkg::ACC_W-1:0] trial;

    assign trial = r_reg + b_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
                busy_reg <= 1'b1;
            else if (busy_reg && cnt_reg == 5'd0)
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    // One result bit per cycle, two radicand bits consumed per step.
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            x_reg   <= radicand;
            r_reg   <= '0;
            b_reg   <= {2'b01, {(chol_pkg::ACC_W-2){1'b0}}};
            cnt_reg <= 5'd31;
        end
        else if (busy_reg)
        begin
            if (x_reg >= trial)
            begin
                x_reg <= x_reg - trial;
                r_reg <= (r_reg >> 1) + b_reg;
            end
            else
                r_reg <= r_reg >> 1;
            b_reg   <= b_reg >> 2;
            cnt_reg <= cnt_reg - 5'd1;
        end
    end

    assign done = done_reg;
    assign root = (r_reg[chol_pkg::ACC_W-1:chol_pkg::DATA_W-1] != '0)
                  ? {1'b0, {(chol_pkg::DATA_W-1){1'b1}}}
                  : r_reg[chol_pkg::DATA_W-1:0];

endmodule
`default_nettype wire

// File: hdl/chol_div.sv
`default_nettype none
module chol_div (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              start,
    input  wire logic signed [chol_pkg::ACC_W-1:0] dividend,
    input  wire logic signed [chol_pkg::DATA_W-1:0] divisor,
    output logic                                   done,
    output logic signed [chol_pkg::DATA_W-1:0]     quotient
);

    logic [chol_pkg::ACC_W-1:0]  m_reg;
    logic [chol_pkg::ACC_W-1:0]  q_reg;
    logic [chol_pkg::DATA_W-1:0] r_reg;
    logic [chol_pkg::DATA_W-1:0] d_reg;
    logic                        neg_reg;
    logic [5:0]                  cnt_reg;
    logic                        busy_reg;
    logic                        done_reg;
    logic [chol_pkg::DATA_W-1:0] r_sh;
    logic [chol_pkg::ACC_W-1:0]  q_abs;

    assign r_sh = {r_reg[chol_pkg::DATA_W-2:0], m_reg[chol_pkg::ACC_W-1]};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
                busy_reg <= 1'b1;
            else if (busy_reg && cnt_reg == 6'd0)
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    // Restoring division on magnitudes, one quotient bit per cycle.
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            neg_reg <= dividend[chol_pkg::ACC_W-1];
            m_reg   <= dividend[chol_pkg::ACC_W-1] ? (~dividend + 64'd1) : dividend;
            d_reg   <= divisor;
            r_reg   <= '0;
            q_reg   <= '0;
            cnt_reg <= 6'd63;
        end
        else if (busy_reg)
        begin
            m_reg <= m_reg << 1;
            if (r_sh >= d_reg)
            begin
                r_reg <= r_sh - d_reg;
                q_reg <= {q_reg[chol_pkg::ACC_W-2:0], 1'b1};
            end
            else
            begin
                r_reg <= r_sh;
                q_reg <= {q_reg[chol_pkg::ACC_W-2:0], 1'b0};
            end
            cnt_reg <= cnt_reg - 6'd1;
        end
    end

    assign q_abs = q_reg;

    always_comb
    begin
        if (!neg_reg)
        begin
            if (q_abs > 64'h0000_0000_7FFF_FFFF)
                quotient = 32'h7FFF_FFFF;
            else
                quotient = q_abs[chol_pkg::DATA_W-1:0];
        end
        else
        begin
            if (q_abs > 64'h0000_0000_8000_0000)
                quotient = 32'h8000_0000;
            else
                quotient = ~q_abs[chol_pkg::DATA_W-1:0] + 32'd1;
        end
    end

    assign done = done_reg;

endmodule
`default_nettype wire

// File: hdl/cholesky_decomposition.sv
// Loading takes one element word per cycle; the last word starts the factorization
// unless a size write comes with it. Each factor entry runs a factor read, multiply
// and saturating add per dot-product term, then a square root or a division.
// Results then leave one word at a time; inputs stall during compute and output.
// Reset sets the size to 8, the tolerance to 1 and the load position to zero.
`default_nettype none
module cholesky_decomposition (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic signed [31:0] element_value,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic signed [31:0] factor_value,
    output logic             failed,
    output logic             end_of_run,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [0:0]  cfg_index,
    input  wire logic [15:0] cfg_data
);

    localparam int DW = chol_pkg::DIM_W;
    localparam int AW = chol_pkg::ADDR_W;

    chol_pkg::state_t state_reg, state_next;

    logic [3:0]  size_reg;
    logic [15:0] tol_reg;
    logic [DW-1:0] ld_row_reg, ld_col_reg;
    logic [DW-1:0] i_reg, j_reg, k_reg, oi_reg, oj_reg;
    logic [DW-1:0] n_last;

    logic signed [31:0] in_mem [chol_pkg::DEPTH];
    logic signed [31:0] f_mem  [chol_pkg::DEPTH];
    logic signed [31:0] a_rd_reg, rd1_reg, rd2_reg;
    logic signed [63:0] prod_reg, acc_reg, rem_reg;
    logic signed [63:0] floor_val;

    logic in_acc, out_acc, cfg_acc;
    logic in_re, f_re, f_we;
    logic [AW-1:0] in_raddr, f_a1, f_a2, f_waddr;
    logic signed [31:0] f_wdata;
    logic sq_start, dv_start, sq_done, dv_done;
    logic signed [31:0] sq_root, dv_quot;
    logic last_load, diag, fail_now;

    assign cfg_ready = 1'b1;
    assign cfg_acc   = cfg_valid & cfg_ready;
    assign in_acc    = in_valid & ~in_stall;
    assign out_acc   = out_valid & ~out_stall;

    assign n_last = (size_reg == 4'd0) ? '0 :
                    (size_reg > 4'(chol_pkg::MAX_DIM)) ? DW'(chol_pkg::MAX_DIM - 1) :
                    DW'(size_reg - 4'd1);
    assign last_load = (ld_row_reg == n_last) && (ld_col_reg == n_last);
    assign diag = (i_reg == j_reg);
    assign floor_val = -$signed({32'd0, tol_reg, 16'd0});
    assign fail_now = diag ? (rem_reg < floor_val) : (rd2_reg <= 32'sd0);

    chol_sqrt u_sqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (sq_start),
        .radicand (rem_reg[63] ? 64'd0 : rem_reg),
        .done     (sq_done),
        .root     (sq_root)
    );

    chol_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (dv_start),
        .dividend (rem_reg),
        .divisor  (rd2_reg),
        .done     (dv_done),
        .quotient (dv_quot)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= chol_pkg::S_LOAD;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        in_stall   = 1'b1;
        out_valid  = 1'b0;
        in_re      = 1'b0;
        in_raddr   = {i_reg, j_reg};
        f_re       = 1'b0;
        f_a1       = {i_reg, k_reg};
        f_a2       = {j_reg, k_reg};
        f_we       = 1'b0;
        f_waddr    = {i_reg, j_reg};
        f_wdata    = diag ? sq_root : dv_quot;
        sq_start   = 1'b0;
        dv_start   = 1'b0;
        case (state_reg)
            chol_pkg::S_LOAD:
            begin
                in_stall = 1'b0;
                if (in_acc && last_load && !(cfg_acc && cfg_index == chol_pkg::CFG_SIZE))
                    state_next = chol_pkg::S_ELEM;
            end
            chol_pkg::S_ELEM:
            begin
                in_re      = 1'b1;
                state_next = chol_pkg::S_MRD;
            end
            chol_pkg::S_MRD:
            begin
                if (k_reg == j_reg)
                    state_next = chol_pkg::S_REM;
                else
                begin
                    f_re       = 1'b1;
                    state_next = chol_pkg::S_MMUL;
                end
            end
            chol_pkg::S_MMUL: state_next = chol_pkg::S_MACC;
            chol_pkg::S_MACC: state_next = chol_pkg::S_MRD;
            chol_pkg::S_REM:
            begin
                f_re       = 1'b1;
                f_a2       = {j_reg, j_reg};
                state_next = chol_pkg::S_DEC;
            end
            chol_pkg::S_DEC:
            begin
                if (fail_now)
                    state_next = chol_pkg::S_FAIL;
                else
                begin
                    sq_start   = diag;
                    dv_start   = ~diag;
                    state_next = chol_pkg::S_WAIT;
                end
            end
            chol_pkg::S_WAIT:
            begin
                if ((diag && sq_done) || (!diag && dv_done))
                begin
                    f_we = 1'b1;
                    if (diag && i_reg == n_last)
                        state_next = chol_pkg::S_ORD;
                    else
                        state_next = chol_pkg::S_ELEM;
                end
            end
            chol_pkg::S_FAIL:
            begin
                out_valid = 1'b1;
                if (out_acc)
                    state_next = chol_pkg::S_LOAD;
            end
            chol_pkg::S_ORD:
            begin
                f_re       = 1'b1;
                f_a1       = {oi_reg, oj_reg};
                state_next = chol_pkg::S_OVAL;
            end
            chol_pkg::S_OVAL:
            begin
                out_valid = 1'b1;
                if (out_acc)
                    state_next = (oi_reg == n_last && oj_reg == n_last)
                                 ? chol_pkg::S_LOAD : chol_pkg::S_ORD;
            end
            default: state_next = chol_pkg::S_LOAD;
        endcase
    end

    // Configuration registers and the load position.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            size_reg   <= 4'd8;
            tol_reg    <= 16'd1;
            ld_row_reg <= '0;
            ld_col_reg <= '0;
        end
        else
        begin
            if (cfg_acc && cfg_index == chol_pkg::CFG_TOL)
                tol_reg <= cfg_data;
            if (cfg_acc && cfg_index == chol_pkg::CFG_SIZE)
            begin
                size_reg   <= cfg_data[3:0];
                ld_row_reg <= '0;
                ld_col_reg <= '0;
            end
            else if (in_acc)
            begin
                if (ld_col_reg == n_last)
                begin
                    ld_col_reg <= '0;
                    ld_row_reg <= (ld_row_reg == n_last) ? '0 : ld_row_reg + 1'b1;
                end
                else
                    ld_col_reg <= ld_col_reg + 1'b1;
            end
        end
    end

    // Loop indices of the factorization and of the output sweep.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            i_reg  <= '0;
            j_reg  <= '0;
            k_reg  <= '0;
            oi_reg <= '0;
            oj_reg <= '0;
        end
        else
        begin
            case (state_reg)
                chol_pkg::S_LOAD:
                begin
                    i_reg  <= '0;
                    j_reg  <= '0;
                    oi_reg <= '0;
                    oj_reg <= '0;
                end
                chol_pkg::S_ELEM: k_reg <= '0;
                chol_pkg::S_MACC: k_reg <= k_reg + 1'b1;
                chol_pkg::S_WAIT:
                begin
                    if (f_we)
                    begin
                        if (diag)
                        begin
                            i_reg <= i_reg + 1'b1;
                            j_reg <= '0;
                        end
                        else
                            j_reg <= j_reg + 1'b1;
                    end
                end
                chol_pkg::S_OVAL:
                begin
                    if (out_acc)
                    begin
                        if (oj_reg == n_last)
                        begin
                            oj_reg <= '0;
                            oi_reg <= oi_reg + 1'b1;
                        end
                        else
                            oj_reg <= oj_reg + 1'b1;
                    end
                end
                default: ;
            endcase
        end
    end

    // Dot-product accumulator and the remainder for the current entry.
    always_ff @(posedge clk)
    begin
        if (state_reg == chol_pkg::S_ELEM)
            acc_reg <= '0;
        if (state_reg == chol_pkg::S_MMUL)
            prod_reg <= rd1_reg * rd2_reg;
        if (state_reg == chol_pkg::S_MACC)
            acc_reg <= chol_pkg::sat_add64(acc_reg, prod_reg);
        if (state_reg == chol_pkg::S_REM)
            rem_reg <= chol_pkg::sat_sub64({a_rd_reg, 32'd0}, acc_reg);
    end

    always_ff @(posedge clk)
    begin
        if (in_acc)
            in_mem[{ld_row_reg, ld_col_reg}] <= element_value;
        if (in_re)
            a_rd_reg <= in_mem[in_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (f_we)
            f_mem[f_waddr] <= f_wdata;
        if (f_re)
        begin
            rd1_reg <= f_mem[f_a1];
            rd2_reg <= f_mem[f_a2];
        end
    end

    assign failed       = (state_reg == chol_pkg::S_FAIL);
    assign factor_value = (state_reg == chol_pkg::S_OVAL && oj_reg <= oi_reg) ? rd1_reg : 32'sd0;
    assign end_of_run   = failed || (oi_reg == n_last && oj_reg == n_last);

endmodule
`default_nettype wire
